[rtl/rqlh_pkg.sv]
// Shared types and constants for the run queue latency histogram.
`default_nettype none
package rqlh_pkg;

    localparam int WAIT_SLOTS_DEF  = 1024;
    localparam int GROUP_SLOTS_DEF = 256;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int ID_BITS      = 22;
    localparam int TIME_BITS    = 64;
    localparam int KEY_BITS     = 64;
    localparam int OUT_BITS     = 32;
    localparam int EDGE_BITS    = 32;
    localparam int NCNT         = 6;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [2:0] OP_WAKEUP      = 3'd0;
    localparam logic [2:0] OP_SWITCH      = 3'd1;
    localparam logic [2:0] OP_EXIT        = 3'd2;
    localparam logic [2:0] OP_GRP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_READ_GRP    = 3'd4;
    localparam logic [2:0] OP_READ_GLOBAL = 3'd5;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_TIME  = 2'd2;
    localparam logic [1:0] ST_NO_GROUP = 2'd3;

    localparam logic [2:0] CNT_VOL   = 3'd0;
    localparam logic [2:0] CNT_INVOL = 3'd1;
    localparam logic [2:0] CNT_B1    = 3'd2;
    localparam logic [2:0] CNT_B2    = 3'd3;
    localparam logic [2:0] CNT_B3    = 3'd4;
    localparam logic [2:0] CNT_B4    = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_ONE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_TWO   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_THREE = 2'd2;

    localparam logic [EDGE_BITS-1:0] EDGE_ONE_RST   = 32'd10000000;
    localparam logic [EDGE_BITS-1:0] EDGE_TWO_RST   = 32'd20000000;
    localparam logic [EDGE_BITS-1:0] EDGE_THREE_RST = 32'd50000000;

    typedef struct packed {
        logic [2:0]           opcode;
        logic [TIME_BITS-1:0] now_ns;
        logic [ID_BITS-1:0]   prev_id;
        logic                 prev_runnable;
        logic [KEY_BITS-1:0]  prev_group;
        logic [ID_BITS-1:0]   next_id;
        logic [KEY_BITS-1:0]  next_group;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic [OUT_BITS-1:0] voluntary_count;
        logic [OUT_BITS-1:0] involuntary_count;
        logic [OUT_BITS-1:0] bucket_one_count;
        logic [OUT_BITS-1:0] bucket_two_count;
        logic [OUT_BITS-1:0] bucket_three_count;
        logic [OUT_BITS-1:0] bucket_four_count;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic f_store;
        logic f_prev_grp;
        logic f_next;
        logic f_exit;
        logic f_grm;
        logic f_grd;
        logic f_gbl;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bstat;

endpackage
`default_nettype wire

[rtl/rqlh_front.sv]
// Front end: takes items, decodes them into commands and queues them.
`default_nettype none
module rqlh_front
    import rqlh_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_in    i_item,
    input  wire t_bstat i_bstat,
    output logic        o_busy,
    output logic        o_cmd_vld,
    output t_cmd        o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       c_cmd;
    logic       c_push;
    logic       c_pid_nz;
    logic       c_nid_nz;

    always_comb begin
        c_pid_nz         = |i_item.prev_id;
        c_nid_nz         = |i_item.next_id;
        c_cmd.item       = i_item;
        c_cmd.f_store    = ((i_item.opcode == OP_WAKEUP) && c_pid_nz) ||
                           ((i_item.opcode == OP_SWITCH) && i_item.prev_runnable && c_pid_nz);
        c_cmd.f_prev_grp = (i_item.opcode == OP_SWITCH) && c_pid_nz && (|i_item.prev_group);
        c_cmd.f_next     = (i_item.opcode == OP_SWITCH) && c_nid_nz;
        c_cmd.f_exit     = i_item.opcode == OP_EXIT;
        c_cmd.f_grm      = i_item.opcode == OP_GRP_REMOVE;
        c_cmd.f_grd      = i_item.opcode == OP_READ_GRP;
        c_cmd.f_gbl      = i_item.opcode == OP_READ_GLOBAL;
    end

    assign o_busy    = (r_cnt == 2'd2) || i_bstat.clearing;
    assign c_push    = i_start && !o_busy;
    assign o_cmd_vld = r_cnt != 2'd0;
    assign o_cmd     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wp] <= c_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) begin
                r_wp <= !r_wp;
            end
            if (i_bstat.pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, c_push} - {1'b0, i_bstat.pop};
        end
    end

endmodule
`default_nettype wire

[rtl/rqlh_back.sv]
// Back end: table scans, counter updates and result register.
`default_nettype none
module rqlh_back
    import rqlh_pkg::*;
#(
    parameter int WAIT_SLOTS  = WAIT_SLOTS_DEF,
    parameter int GROUP_SLOTS = GROUP_SLOTS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cmd_vld,
    input  wire t_cmd                 i_cmd,
    input  wire logic [EDGE_BITS-1:0] i_edge_one,
    input  wire logic [EDGE_BITS-1:0] i_edge_two,
    input  wire logic [EDGE_BITS-1:0] i_edge_three,
    output t_bstat                    o_bstat,
    output logic                      o_done,
    output t_out                      o_result
);

    localparam int MAXS = (WAIT_SLOTS > GROUP_SLOTS) ? WAIT_SLOTS : GROUP_SLOTS;
    localparam int IW   = $clog2(MAXS);
    localparam int WW   = $clog2(WAIT_SLOTS);
    localparam int GW   = $clog2(GROUP_SLOTS);
    localparam logic [IW:0] WS_N     = (IW+1)'(WAIT_SLOTS);
    localparam logic [IW:0] GS_N     = (IW+1)'(GROUP_SLOTS);
    localparam logic [IW:0] CLR_LAST = (IW+1)'(MAXS - 1);

    typedef logic [NCNT-1:0][COUNT_BITS-1:0] t_cnts;

    typedef struct packed {
        logic                 vld;
        logic [ID_BITS-1:0]   task_id;
        logic [TIME_BITS-1:0] tstamp;
    } t_went;

    typedef struct packed {
        logic                vld;
        logic [KEY_BITS-1:0] key;
        t_cnts               cnt;
    } t_gent;

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_SCAN, S_ACT} t_state;
    typedef enum logic [2:0] {P_STORE, P_PGRP, P_NEXT, P_NGRP, P_EXIT, P_GRM, P_GRD} t_phase;

    function automatic logic [COUNT_BITS-1:0] sinc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic t_cnts inc6(input t_cnts c, input logic [2:0] which);
        t_cnts r;
        for (int k = 0; k < NCNT; k++) begin
            r[k] = (3'(k) == which) ? sinc(c[k]) : c[k];
        end
        return r;
    endfunction

    function automatic logic [OUT_BITS-1:0] osat(input logic [COUNT_BITS-1:0] v);
        logic [63:0] e;
        e = 64'(v);
        return (|e[63:32]) ? '1 : e[31:0];
    endfunction

    function automatic t_out mkout(input logic [1:0] st, input t_cnts c);
        t_out r;
        r.status             = st;
        r.voluntary_count    = osat(c[CNT_VOL]);
        r.involuntary_count  = osat(c[CNT_INVOL]);
        r.bucket_one_count   = osat(c[CNT_B1]);
        r.bucket_two_count   = osat(c[CNT_B2]);
        r.bucket_three_count = osat(c[CNT_B3]);
        r.bucket_four_count  = osat(c[CNT_B4]);
        return r;
    endfunction

    t_went r_wmem [WAIT_SLOTS];
    t_gent r_gmem [GROUP_SLOTS];
    t_went r_wrd;
    t_gent r_grd;

    t_state               r_state;
    t_phase               r_phase;
    t_cmd                 r_cmd;
    logic [IW:0]          r_idx;
    logic                 r_pend;
    logic [IW-1:0]        r_pidx;
    logic                 r_found;
    logic [IW-1:0]        r_fidx;
    logic                 r_free;
    logic [IW-1:0]        r_free_idx;
    logic [TIME_BITS-1:0] r_mtime;
    t_cnts                r_mcnt;
    t_cnts                r_glob;
    logic [TIME_BITS-1:0] r_delta;
    logic [1:0]           r_status;
    logic                 r_odone;
    t_out                 r_ores;

    logic                 w_we;
    logic [WW-1:0]        w_wa;
    t_went                w_wd;
    logic                 g_we;
    logic [GW-1:0]        g_wa;
    t_gent                g_wd;

    logic [KEY_BITS-1:0]  key_cur;
    logic                 tbl_grp;
    logic [IW:0]          tbl_n;
    logic                 s_hit;
    logic                 s_vac;
    logic                 c_any;
    t_phase               c_first;
    logic                 a_have;
    logic [IW-1:0]        a_slot;
    logic [2:0]           a_which;
    t_cnts                a_newcnt;
    t_cnts                a_newglob;
    logic                 a_fin;
    t_phase               a_nphase;
    logic [1:0]           a_status;
    t_out                 a_res;

    // table lookups
    always_comb begin
        case (r_phase)
            P_STORE, P_EXIT: key_cur = KEY_BITS'(r_cmd.item.prev_id);
            P_NEXT:          key_cur = KEY_BITS'(r_cmd.item.next_id);
            P_NGRP:          key_cur = r_cmd.item.next_group;
            default:         key_cur = r_cmd.item.prev_group;
        endcase
        tbl_grp = (r_phase == P_PGRP) || (r_phase == P_NGRP) ||
                  (r_phase == P_GRM) || (r_phase == P_GRD);
        tbl_n   = tbl_grp ? GS_N : WS_N;
        if (tbl_grp) begin
            s_hit = r_grd.vld && (r_grd.key == key_cur);
            s_vac = !r_grd.vld;
        end else begin
            s_hit = r_wrd.vld && (r_wrd.task_id == key_cur[ID_BITS-1:0]);
            s_vac = !r_wrd.vld;
        end
    end

    // first step of a new command
    always_comb begin
        c_any = i_cmd.f_store || i_cmd.f_prev_grp || i_cmd.f_next || i_cmd.f_exit ||
                i_cmd.f_grm || i_cmd.f_grd;
        if (i_cmd.f_store) begin
            c_first = P_STORE;
        end else if (i_cmd.f_prev_grp) begin
            c_first = P_PGRP;
        end else if (i_cmd.f_next) begin
            c_first = P_NEXT;
        end else if (i_cmd.f_exit) begin
            c_first = P_EXIT;
        end else if (i_cmd.f_grm) begin
            c_first = P_GRM;
        end else begin
            c_first = P_GRD;
        end
    end

    // action after a scan
    always_comb begin
        a_have = r_found || r_free;
        a_slot = r_found ? r_fidx : r_free_idx;
        if (r_phase == P_PGRP) begin
            a_which = r_cmd.item.prev_runnable ? CNT_INVOL : CNT_VOL;
        end else if (r_delta < 64'(i_edge_one)) begin
            a_which = CNT_B1;
        end else if (r_delta < 64'(i_edge_two)) begin
            a_which = CNT_B2;
        end else if (r_delta < 64'(i_edge_three)) begin
            a_which = CNT_B3;
        end else begin
            a_which = CNT_B4;
        end
        a_newcnt  = inc6(r_found ? r_mcnt : '0, a_which);
        a_newglob = inc6(r_glob, a_which);
        a_fin     = 1'b1;
        a_nphase  = P_STORE;
        a_status  = r_status;
        case (r_phase)
            P_STORE: begin
                if (!a_have) begin
                    a_status = ST_FULL;
                end
                if (r_cmd.f_prev_grp) begin
                    a_fin    = 1'b0;
                    a_nphase = P_PGRP;
                end else if (r_cmd.f_next) begin
                    a_fin    = 1'b0;
                    a_nphase = P_NEXT;
                end
            end
            P_PGRP: begin
                if (!a_have) begin
                    a_status = ST_FULL;
                end else if (r_cmd.f_next) begin
                    a_fin    = 1'b0;
                    a_nphase = P_NEXT;
                end
            end
            P_NEXT: begin
                if (!r_found || (r_mtime == '0)) begin
                    a_status = (r_status != ST_DONE) ? r_status : ST_NO_TIME;
                end else if (|r_cmd.item.next_group) begin
                    a_fin    = 1'b0;
                    a_nphase = P_NGRP;
                end
            end
            P_NGRP: begin
                if (!a_have) begin
                    a_status = ST_FULL;
                end
            end
            P_GRM, P_GRD: begin
                if (!r_found) begin
                    a_status = ST_NO_GROUP;
                end
            end
            default: ;
        endcase
        a_res = mkout(a_status, ((r_phase == P_GRD) && r_found) ? r_mcnt : '0);
    end

    // memory write port
    always_comb begin
        w_we = 1'b0;
        w_wa = r_idx[WW-1:0];
        w_wd = '0;
        g_we = 1'b0;
        g_wa = r_idx[GW-1:0];
        g_wd = '0;
        case (r_state)
            S_CLR: begin
                w_we = r_idx < WS_N;
                g_we = r_idx < GS_N;
            end
            S_ACT: begin
                case (r_phase)
                    P_STORE: begin
                        w_we = a_have;
                        w_wa = a_slot[WW-1:0];
                        w_wd = '{vld: 1'b1, task_id: r_cmd.item.prev_id,
                                 tstamp: r_cmd.item.now_ns};
                    end
                    P_NEXT: begin
                        w_we = r_found && (r_mtime != '0);
                        w_wa = r_fidx[WW-1:0];
                    end
                    P_EXIT: begin
                        w_we = r_found;
                        w_wa = r_fidx[WW-1:0];
                    end
                    P_PGRP, P_NGRP: begin
                        g_we = a_have;
                        g_wa = a_slot[GW-1:0];
                        g_wd = '{vld: 1'b1, key: key_cur, cnt: a_newcnt};
                    end
                    P_GRM: begin
                        g_we = r_found;
                        g_wa = r_fidx[GW-1:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_wa] <= w_wd;
        end
        r_wrd <= r_wmem[r_idx[WW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_gmem[g_wa] <= g_wd;
        end
        r_grd <= r_gmem[r_idx[GW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_phase  <= P_STORE;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_free   <= 1'b0;
            r_glob   <= '0;
            r_status <= ST_DONE;
            r_odone  <= 1'b0;
        end else begin
            r_odone <= 1'b0;
            case (r_state)
                S_CLR: begin
                    if (r_idx == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_cmd    <= i_cmd;
                        r_status <= ST_DONE;
                        if (c_any) begin
                            r_state <= S_SCAN;
                            r_phase <= c_first;
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_found <= 1'b0;
                            r_free  <= 1'b0;
                        end else begin
                            r_odone <= 1'b1;
                            r_ores  <= mkout(ST_DONE, i_cmd.f_gbl ? r_glob : '0);
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pend && s_hit && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_pidx;
                        r_mtime <= r_wrd.tstamp;
                        r_mcnt  <= r_grd.cnt;
                    end
                    if (r_pend && s_vac && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_pidx;
                    end
                    // issue the next read while the previous one is compared
                    if (r_idx != tbl_n) begin
                        r_idx  <= r_idx + 1'b1;
                        r_pend <= 1'b1;
                        r_pidx <= r_idx[IW-1:0];
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_ACT;
                        end
                    end
                end
                S_ACT: begin
                    r_status <= a_status;
                    if (((r_phase == P_PGRP) || (r_phase == P_NGRP)) && a_have) begin
                        r_glob <= a_newglob;
                    end
                    if (r_phase == P_NEXT) begin
                        r_delta <= r_cmd.item.now_ns - r_mtime;
                    end
                    if (a_fin) begin
                        r_state <= S_IDLE;
                        r_odone <= 1'b1;
                        r_ores  <= a_res;
                    end else begin
                        r_state <= S_SCAN;
                        r_phase <= a_nphase;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_free  <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_bstat.pop      = (r_state == S_IDLE) && i_cmd_vld;
    assign o_bstat.clearing = r_state == S_CLR;
    assign o_done           = r_odone;
    assign o_result         = r_ores;

    a_no_done_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !r_odone)
        else $error("result during clearing pass");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(w_we || g_we))
        else $error("table write while idle");

    a_pop_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bstat.pop |=> ((r_state == S_SCAN) || r_odone))
        else $error("popped command neither scanned nor finished");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_pend) |-> ((IW+1)'(r_pidx) < tbl_n))
        else $error("scan index past table end");

endmodule
`default_nettype wire

[rtl/run_queue_latency_histogram.sv]
// A read of the global set is answered without a table scan.
// Each table lookup is a linear scan, one entry per cycle through the table's
// single read port; one command is carried out at a time, two may wait queued.
// After reset a clearing pass over both tables holds busy.
// Results are shown for one cycle with o_done; the receiver cannot stall.
`default_nettype none
module run_queue_latency_histogram
    import rqlh_pkg::*;
#(
    parameter int WAIT_SLOTS  = WAIT_SLOTS_DEF,
    parameter int GROUP_SLOTS = GROUP_SLOTS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire t_in                     i_item,
    output logic                         o_done,
    output t_out                         o_result,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [EDGE_BITS-1:0]    i_cfg_data
);

    logic [EDGE_BITS-1:0] r_edge_one;
    logic [EDGE_BITS-1:0] r_edge_two;
    logic [EDGE_BITS-1:0] r_edge_three;
    logic                 cmd_vld;
    t_cmd                 cmd;
    t_bstat               bstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_one   <= EDGE_ONE_RST;
            r_edge_two   <= EDGE_TWO_RST;
            r_edge_three <= EDGE_THREE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EDGE_ONE:   r_edge_one   <= i_cfg_data;
                CFG_EDGE_TWO:   r_edge_two   <= i_cfg_data;
                CFG_EDGE_THREE: r_edge_three <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rqlh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_bstat   (bstat),
        .o_busy    (busy),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd)
    );

    rqlh_back #(
        .WAIT_SLOTS  (WAIT_SLOTS),
        .GROUP_SLOTS (GROUP_SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_vld    (cmd_vld),
        .i_cmd        (cmd),
        .i_edge_one   (r_edge_one),
        .i_edge_two   (r_edge_two),
        .i_edge_three (r_edge_three),
        .o_bstat      (bstat),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule
`default_nettype wire
